[design/frame_deframer_crc16_macros.svh]
// assertion macros for the deframer checker
`ifndef FRAME_DEFRAMER_CRC16_MACROS_SVH
`define FRAME_DEFRAMER_CRC16_MACROS_SVH
// implication checked every cycle outside reset
`define FDC_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");
// next-cycle implication checked outside reset
`define FDC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[design/fdc_pkg.sv]
// shared types and constants for the deframer
package fdc_pkg;
  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_CRC} phase_t;
  typedef enum logic [1:0] {REG_START_FIRST, REG_START_SECOND, REG_MAX_PAYLOAD,
                            REG_NONE} reg_idx_t;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int HDR_BYTES = 7;
  localparam int QUEUE_DEPTH = 2;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  msg_type;
    logic [7:0]  flag_bits;
    logic [15:0] sequence_res;
    logic [15:0] payload_len;
    logic        is_last;
    logic        crc_ok;
  } result_t;
endpackage

[design/fdc_front.sv]
// front part: hunts, collects header, checks crc, classifies bytes into results
module fdc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [7:0]             in_byte,
  output logic                   in_take,
  input  logic [7:0]             start_first,
  input  logic [7:0]             start_second,
  input  logic [15:0]            max_payload,
  output logic                   res_valid,
  output fdc_pkg::result_t       res,
  input  logic                   res_room
);
  import fdc_pkg::*;

  phase_t      phase, phase_next;
  logic        saw_first, saw_first_next;
  logic [7:0]  hdr [HDR_BYTES];
  logic [2:0]  hcount, hcount_next;
  logic [15:0] pcount, pcount_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_low, crc_low_next;
  // rescan of stored header bytes after a bad length
  logic        rescan, rescan_next;
  logic [2:0]  rs_idx, rs_idx_next;
  logic [7:0]  rs_copy [HDR_BYTES];
  logic        hdr_wr;
  logic        copy_wr;
  logic [7:0]  cur;
  logic        step;
  logic [15:0] hlen;

  assign hlen = {hdr[6], hdr[5]};
  assign in_take = !rescan && res_room;
  assign step = rescan || (in_valid && res_room);
  assign cur = rescan ? rs_copy[rs_idx] : in_byte;

  always_comb begin
    phase_next = phase;
    saw_first_next = saw_first;
    hcount_next = hcount;
    pcount_next = pcount;
    crc_next = crc;
    crc_low_next = crc_low;
    rescan_next = rescan;
    rs_idx_next = rs_idx;
    hdr_wr = 1'b0;
    copy_wr = 1'b0;
    res_valid = 1'b0;
    res = '{data_byte: cur, msg_type: hdr[1], flag_bits: hdr[2],
            sequence_res: {hdr[4], hdr[3]}, payload_len: hlen,
            is_last: 1'b0, crc_ok: 1'b0};
    if (step) begin
      if (rescan) begin
        rs_idx_next = rs_idx + 3'd1;
        if (rs_idx == 3'(HDR_BYTES - 1)) rescan_next = 1'b0;
      end
      case (phase)
        PH_HUNT: begin
          if (saw_first && cur == start_second) begin
            phase_next = PH_HEADER;
            hcount_next = '0;
            saw_first_next = 1'b0;
            crc_next = crc_byte(crc_byte(CRC_INIT, start_first), start_second);
          end else begin
            saw_first_next = (cur == start_first);
          end
        end
        PH_HEADER: begin
          hdr_wr = 1'b1;
          crc_next = crc_byte(crc, cur);
          hcount_next = hcount + 3'd1;
          if (hcount == 3'(HDR_BYTES - 1)) begin
            // length check uses the byte arriving now as the high length byte
            if ({cur, hdr[5]} > max_payload) begin
              phase_next = PH_HUNT;
              saw_first_next = 1'b0;
              hcount_next = '0;
              copy_wr = 1'b1;
              rescan_next = 1'b1;
              rs_idx_next = '0;
            end else begin
              pcount_next = '0;
              saw_first_next = 1'b0;
              phase_next = ({cur, hdr[5]} == 16'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_next = crc_byte(crc, cur);
          pcount_next = pcount + 16'd1;
          res_valid = 1'b1;
          if (pcount + 16'd1 >= hlen) phase_next = PH_CRC;
        end
        default: begin
          if (!saw_first) begin
            crc_low_next = cur;
            saw_first_next = 1'b1;
          end else begin
            res_valid = 1'b1;
            res.data_byte = '0;
            res.is_last = 1'b1;
            res.crc_ok = ({cur, crc_low} == crc);
            phase_next = PH_HUNT;
            saw_first_next = 1'b0;
            hcount_next = '0;
            pcount_next = '0;
            crc_next = CRC_INIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      saw_first <= 1'b0;
      hcount <= '0;
      pcount <= '0;
      crc <= CRC_INIT;
      crc_low <= '0;
      rescan <= 1'b0;
      rs_idx <= '0;
    end else begin
      phase <= phase_next;
      saw_first <= saw_first_next;
      hcount <= hcount_next;
      pcount <= pcount_next;
      crc <= crc_next;
      crc_low <= crc_low_next;
      rescan <= rescan_next;
      rs_idx <= rs_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr) hdr[hcount] <= cur;
    if (copy_wr) begin
      for (int i = 0; i < HDR_BYTES - 1; i++) rs_copy[i] <= hdr[i];
      rs_copy[HDR_BYTES - 1] <= cur;
    end
  end
endmodule

[design/fdc_queue.sv]
// short queue between front and output side
module fdc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  fdc_pkg::result_t wr_data,
  output logic             wr_room,
  output logic             rd_valid,
  output fdc_pkg::result_t rd_data,
  input  logic             rd_take
);
  import fdc_pkg::*;

  result_t    mem [QUEUE_DEPTH];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_room = (cnt != 2'(QUEUE_DEPTH));
  assign rd_valid = (cnt != 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_room) wp <= ~wp;
      if (rd_take && rd_valid) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_room) - 2'(rd_take && rd_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_room) mem[wp] <= wr_data;
  end
endmodule

[design/frame_deframer_crc16.sv]
// Byte-serial deframer: hunts a two-byte start mark, collects a seven-byte
// header, passes payload words out tagged and ends each frame with a CRC-16
// verdict word. One input word per cycle while the two-entry output queue has
// room; after a header with an oversized length the front rescans the seven
// stored header bytes and takes no input meanwhile.
module frame_deframer_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [7:0]  msg_type,
  output logic [7:0]  flag_bits,
  output logic [15:0] sequence_res,
  output logic [15:0] payload_len,
  output logic        is_last,
  output logic        crc_ok
);
  import fdc_pkg::*;

  logic [7:0]  start_first, start_second;
  logic [15:0] max_payload;
  logic        take, res_valid, room;
  result_t     res, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first <= 8'h55;
      start_second <= 8'hAA;
      max_payload <= 16'd245;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_START_FIRST:  start_first <= cfg_data[7:0];
        REG_START_SECOND: start_second <= cfg_data[7:0];
        REG_MAX_PAYLOAD:  max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  fdc_front u_front (
    .clk, .rst, .in_valid, .in_byte, .in_take(take),
    .start_first, .start_second, .max_payload,
    .res_valid, .res, .res_room(room)
  );

  assign in_stall = !take;

  fdc_queue u_queue (
    .clk, .rst, .wr_valid(res_valid), .wr_data(res), .wr_room(room),
    .rd_valid(out_valid), .rd_data(q_out), .rd_take(!out_stall)
  );

  assign data_byte = q_out.data_byte;
  assign msg_type = q_out.msg_type;
  assign flag_bits = q_out.flag_bits;
  assign sequence_res = q_out.sequence_res;
  assign payload_len = q_out.payload_len;
  assign is_last = q_out.is_last;
  assign crc_ok = q_out.crc_ok;
endmodule

[design/fdc_checker.sv]
// port-level checks for the deframer
`include "frame_deframer_crc16_macros.svh"
module fdc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_byte,
  input logic       is_last,
  input logic       crc_ok
);
  `FDC_ASSERT_IMP(a_end_zero, clk, rst, out_valid && is_last, data_byte == 8'd0)
  `FDC_ASSERT_IMP(a_pay_nok, clk, rst, out_valid && !is_last, !crc_ok)
  `FDC_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(data_byte))
endmodule

bind frame_deframer_crc16 fdc_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .data_byte, .is_last, .crc_ok
);
